### rtl/tle_pkg.sv
// ============================================================================
// tle_pkg
// Shared types, character codes and helpers for the terminal line editor.
// ============================================================================
`default_nettype none

package tle_pkg;

    localparam int TLE_LINE_MAX  = 64;
    localparam int TLE_CMD_DEPTH = 2;
    localparam int LEN_W         = 7;
    localparam int BYTE_W        = 8;

    localparam logic [BYTE_W-1:0] DELETE_CODE_RESET = 8'd127;

    // APB map: one register per 32-bit word
    localparam int  PADDR_W         = 3;
    localparam logic REG_DELETE_CODE = 1'b0;

    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_B  = 8'h42;
    localparam logic [BYTE_W-1:0] CH_UPPER_C  = 8'h43;
    localparam logic [BYTE_W-1:0] CH_UPPER_D  = 8'h44;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A  = 8'h61;

    typedef enum logic [3:0] {
        EV_IGNORED  = 4'd0,
        EV_ECHO     = 4'd1,
        EV_REDRAW   = 4'd2,
        EV_ERASE    = 4'd3,
        EV_RIGHT    = 4'd4,
        EV_LEFT     = 4'd5,
        EV_LINECHAR = 4'd6,
        EV_EMPTY    = 4'd7,
        EV_PENDING  = 4'd8,
        EV_UP       = 4'd9,
        EV_DOWN     = 4'd10
    } ev_kind_t;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SEEN,
        ESC_BRACKET
    } esc_stage_t;

    typedef enum logic [3:0] {
        OP_IGNORE,
        OP_PENDING,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_ENTER,
        OP_DELETE,
        OP_INSERT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [BYTE_W-1:0]  data;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SHR,
        BK_SHR_LAST,
        BK_SHL,
        BK_EMIT
    } back_state_t;

    function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c + (CH_LOWER_A - CH_UPPER_A);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/tle_if.sv
// ============================================================================
// tle_if
// Valid/ready channels: received bytes in, editor events out.
// ============================================================================
`default_nettype none

interface tle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_ev_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_kind;
    logic [7:0] out_byte;
    logic [6:0] line_length;
    logic [6:0] cursor_pos;
    logic       last;

    modport source (output valid, output event_kind, output out_byte,
                    output line_length, output cursor_pos, output last, input ready);
    modport sink   (input valid, input event_kind, input out_byte,
                    input line_length, input cursor_pos, input last, output ready);
endinterface

`default_nettype wire

### rtl/terminal_line_editor.sv
// ============================================================================
// terminal_line_editor
// Command-line editor for a received terminal byte stream.
// ============================================================================
// Bytes enter on rx and are classified at once into a two-entry command
// queue; the line engine behind it emits events on ev through an output
// register. Inserting inside the line moves the tail through the line
// memory (one write and one read port) one entry a cycle; deleting inside
// the line pulls the tail left one entry a cycle. Enter gives one event
// per line character, one a cycle while ev is ready, after a registered
// read of the first entry. The delete code is set over APB at word address 0.
`default_nettype none

module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_MAX = TLE_LINE_MAX
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    tle_rx_if.sink                  rx,
    tle_ev_if.source                ev,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    logic [BYTE_W-1:0] delete_code_reg;
    logic              cfg_wr;
    logic              push;
    cmd_t              push_cmd;
    logic              full;
    logic              pop;
    logic              not_empty;
    cmd_t              head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DELETE_CODE);
    assign prdata = (paddr[2] == REG_DELETE_CODE) ? {24'd0, delete_code_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delete_code_reg <= DELETE_CODE_RESET;
        end
        else if (cfg_wr)
        begin
            delete_code_reg <= pwdata[BYTE_W-1:0];
        end
    end

    tle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .delete_code (delete_code_reg),
        .full        (full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    tle_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    tle_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .ev         (ev)
    );

endmodule

`default_nettype wire

### rtl/tle_front.sv
// ============================================================================
// tle_front
// Accepts received bytes, tracks ESC [ x sequences and classifies each byte
// into an editor command.
// ============================================================================
`default_nettype none

module tle_front
    import tle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    tle_rx_if.sink                 rx,
    input  wire logic [BYTE_W-1:0] delete_code,
    input  wire logic              full,
    output logic                   push,
    output cmd_t                   push_cmd
);

    esc_stage_t esc_reg;
    esc_stage_t esc_next;
    cmd_op_t    op;

    assign rx.ready = !full;
    assign push     = rx.valid && !full;

    always_comb
    begin
        op       = OP_IGNORE;
        esc_next = ESC_IDLE;
        case (esc_reg)
            ESC_SEEN:
            begin
                if (rx.rx_byte == CH_LBRACKET)
                begin
                    op       = OP_PENDING;
                    esc_next = ESC_BRACKET;
                end
            end
            ESC_BRACKET:
            begin
                case (rx.rx_byte)
                    CH_UPPER_A: op = OP_UP;
                    CH_UPPER_B: op = OP_DOWN;
                    CH_UPPER_C: op = OP_RIGHT;
                    CH_UPPER_D: op = OP_LEFT;
                    default:    op = OP_IGNORE;
                endcase
            end
            default:
            begin
                // ESC beats enter, enter beats the delete code
                if (rx.rx_byte == CH_ESC)
                begin
                    op       = OP_PENDING;
                    esc_next = ESC_SEEN;
                end
                else if (rx.rx_byte == CH_CR || rx.rx_byte == CH_LF
                         || rx.rx_byte == CH_NUL)
                begin
                    op = OP_ENTER;
                end
                else if (rx.rx_byte == delete_code)
                begin
                    op = OP_DELETE;
                end
                else
                begin
                    op = OP_INSERT;
                end
            end
        endcase
    end

    assign push_cmd.op   = op;
    assign push_cmd.data = rx.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= ESC_IDLE;
        end
        else if (push)
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tle_fifo.sv
// ============================================================================
// tle_fifo
// Short command queue between the classifier and the line engine.
// ============================================================================
`default_nettype none

module tle_fifo
    import tle_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    localparam int PW = (TLE_CMD_DEPTH > 1) ? $clog2(TLE_CMD_DEPTH) : 1;
    localparam int CW = $clog2(TLE_CMD_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(TLE_CMD_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(TLE_CMD_DEPTH);

    cmd_t          slot_reg [TLE_CMD_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/tle_back.sv
// ============================================================================
// tle_back
// Line engine: holds the line memory, length and cursor, carries out one
// command at a time and drives the event output register.
// ============================================================================
`default_nettype none

module tle_back
    import tle_pkg::*;
#(
    parameter int LINE_MAX = TLE_LINE_MAX
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic head_valid,
    output logic      pop,
    tle_ev_if.source  ev
);

    localparam int IW = $clog2(LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_MAX);

    logic [BYTE_W-1:0] mem [LINE_MAX];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [IW-1:0]     mem_raddr;

    back_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cur_reg, cur_next;
    logic [IW-1:0]     ptr_reg, ptr_next;
    logic [IW-1:0]     stop_reg, stop_next;
    logic [BYTE_W-1:0] ins_reg, ins_next;

    logic              ev_valid_reg, ev_valid_next;
    ev_kind_t          ev_kind_reg, ev_kind_next;
    logic [BYTE_W-1:0] ev_byte_reg, ev_byte_next;
    logic [LEN_W-1:0]  ev_len_reg, ev_len_next;
    logic [LEN_W-1:0]  ev_cur_reg, ev_cur_next;
    logic              ev_last_reg, ev_last_next;

    logic              out_free;
    logic [LEN_W-1:0]  len_dec;
    logic [IW-1:0]     ptr_inc;
    logic [IW-1:0]     ptr_dec;

    assign out_free = !ev_valid_reg || ev.ready;
    assign len_dec  = len_reg - 1'b1;
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;

    always_comb
    begin
        logic              res_emit;
        ev_kind_t          res_kind;
        logic [BYTE_W-1:0] res_byte;

        res_emit      = 1'b0;
        res_kind      = EV_IGNORED;
        res_byte      = '0;
        state_next    = state_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        ptr_next      = ptr_reg;
        stop_next     = stop_reg;
        ins_next      = ins_reg;
        ev_valid_next = ev_valid_reg && !ev.ready;
        ev_kind_next  = ev_kind_reg;
        ev_byte_next  = ev_byte_reg;
        ev_len_next   = ev_len_reg;
        ev_cur_next   = ev_cur_reg;
        ev_last_next  = ev_last_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = rd_data_reg;
        mem_raddr     = ptr_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    pop      = 1'b1;
                    res_emit = 1'b1;
                    case (head.op)
                        OP_PENDING: res_kind = EV_PENDING;
                        OP_UP:      res_kind = EV_UP;
                        OP_DOWN:    res_kind = EV_DOWN;
                        OP_RIGHT:
                        begin
                            if (cur_reg < len_reg)
                            begin
                                cur_next = cur_reg + 1'b1;
                                res_kind = EV_RIGHT;
                            end
                        end
                        OP_LEFT:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next = cur_reg - 1'b1;
                                res_kind = EV_LEFT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (len_reg != '0 && cur_reg != '0)
                            begin
                                len_next = len_dec;
                                cur_next = cur_reg - 1'b1;
                                if (cur_reg == len_reg)
                                begin
                                    res_kind = EV_ERASE;
                                end
                                else
                                begin
                                    // pull the tail left, one entry a cycle
                                    res_kind   = EV_REDRAW;
                                    mem_raddr  = cur_reg[IW-1:0];
                                    ptr_next   = cur_reg[IW-1:0];
                                    stop_next  = len_dec[IW-1:0];
                                    state_next = BK_SHL;
                                end
                            end
                        end
                        OP_INSERT:
                        begin
                            if (len_reg < LEN_MAX)
                            begin
                                len_next = len_reg + 1'b1;
                                cur_next = cur_reg + 1'b1;
                                if (cur_reg == len_reg)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = len_reg[IW-1:0];
                                    mem_wdata = head.data;
                                    res_kind  = EV_ECHO;
                                    res_byte  = head.data;
                                end
                                else
                                begin
                                    // push the tail right from the end down
                                    res_kind   = EV_REDRAW;
                                    mem_raddr  = len_dec[IW-1:0];
                                    ptr_next   = len_dec[IW-1:0];
                                    stop_next  = cur_reg[IW-1:0];
                                    ins_next   = head.data;
                                    state_next = BK_SHR;
                                end
                            end
                        end
                        OP_ENTER:
                        begin
                            if (len_reg == '0)
                            begin
                                res_kind = EV_EMPTY;
                            end
                            else
                            begin
                                res_emit   = 1'b0;
                                len_next   = '0;
                                cur_next   = '0;
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                stop_next  = len_dec[IW-1:0];
                                state_next = BK_EMIT;
                            end
                        end
                        default: res_kind = EV_IGNORED;
                    endcase
                end
            end
            BK_SHR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_inc;
                if (ptr_reg == stop_reg)
                begin
                    state_next = BK_SHR_LAST;
                end
                else
                begin
                    ptr_next  = ptr_dec;
                    mem_raddr = ptr_dec;
                end
            end
            BK_SHR_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = stop_reg;
                mem_wdata  = ins_reg;
                state_next = BK_IDLE;
            end
            BK_SHL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_dec;
                if (ptr_reg == stop_reg)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    ptr_next  = ptr_inc;
                    mem_raddr = ptr_inc;
                end
            end
            BK_EMIT:
            begin
                // re-read the same entry while the output is stalled
                if (out_free)
                begin
                    ev_valid_next = 1'b1;
                    ev_kind_next  = EV_LINECHAR;
                    ev_byte_next  = fold_lower(rd_data_reg);
                    ev_len_next   = len_reg;
                    ev_cur_next   = cur_reg;
                    ev_last_next  = (ptr_reg == stop_reg);
                    if (ptr_reg == stop_reg)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        ptr_next  = ptr_inc;
                        mem_raddr = ptr_inc;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase

        if (res_emit)
        begin
            ev_valid_next = 1'b1;
            ev_kind_next  = res_kind;
            ev_byte_next  = res_byte;
            ev_len_next   = len_next;
            ev_cur_next   = cur_next;
            ev_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            len_reg      <= '0;
            cur_reg      <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cur_reg      <= cur_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        stop_reg    <= stop_next;
        ins_reg     <= ins_next;
        ev_kind_reg <= ev_kind_next;
        ev_byte_reg <= ev_byte_next;
        ev_len_reg  <= ev_len_next;
        ev_cur_reg  <= ev_cur_next;
        ev_last_reg <= ev_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign ev.valid       = ev_valid_reg;
    assign ev.event_kind  = ev_kind_reg;
    assign ev.out_byte    = ev_byte_reg;
    assign ev.line_length = ev_len_reg;
    assign ev.cursor_pos  = ev_cur_reg;
    assign ev.last        = ev_last_reg;

endmodule

`default_nettype wire

### rtl/tle_checker.sv
// ============================================================================
// tle_checker
// Port-level checks on the event output of the line editor.
// ============================================================================
`default_nettype none

module tle_checker
    import tle_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       ev_valid,
    input wire logic       ev_ready,
    input wire logic [3:0] event_kind,
    input wire logic [7:0] out_byte,
    input wire logic [6:0] line_length,
    input wire logic [6:0] cursor_pos,
    input wire logic       last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(event_kind) && $stable(out_byte)
            && $stable(line_length) && $stable(cursor_pos) && $stable(last))
        else $error("event changed while stalled");

    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> cursor_pos <= line_length)
        else $error("cursor beyond line end");

    a_linechar: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind == EV_LINECHAR |-> line_length == 7'd0 && cursor_pos == 7'd0)
        else $error("line not cleared during emit");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind != EV_LINECHAR |-> last)
        else $error("single-result event without last");

    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind == EV_ECHO |-> cursor_pos == line_length && line_length != 7'd0)
        else $error("echo not at line end");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_valid    (ev.valid),
    .ev_ready    (ev.ready),
    .event_kind  (ev.event_kind),
    .out_byte    (ev.out_byte),
    .line_length (ev.line_length),
    .cursor_pos  (ev.cursor_pos),
    .last        (ev.last)
);

`default_nettype wire

### dv/terminal_line_editor_test.sv
// ============================================================================
// terminal_line_editor_test
// Self-checking bench for the terminal line editor. Bytes go in on the rx
// channel and the editor events come back on the ev channel. A local copy of
// the line state is kept: line buffer, length, cursor, escape stage and
// delete code. That copy predicts every event, and each event is checked
// field by field as it is accepted. The run opens with a directed pass. It
// then runs random typing in several delete-code settings, with random
// stalls on both channels.
// ============================================================================
`default_nettype none

module terminal_line_editor_test;
    import tle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 27;
    localparam int HOLD_CYCLES = 400;
    localparam logic [PADDR_W-1:0] DELETE_CODE_ADDR = PADDR_W'(4 * REG_DELETE_CODE);

    typedef struct {
        ev_kind_t   kind;
        logic [7:0] ch;
        logic [6:0] len;
        logic [6:0] cur;
        logic       last;
    } line_event_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    tle_rx_if rx_ch ();
    tle_ev_if ev_ch ();

    // shadow of the editor state
    logic [7:0]  line_mem [TLE_LINE_MAX];
    int          line_len;
    int          cur_pos;
    esc_stage_t  esc_state;
    logic [7:0]  del_code;

    logic [7:0]  rx_pending [$];
    line_event_t line_events_due [$];
    int          mismatches;
    logic        rx_taken;
    logic        no_idle;
    logic        hold_go;
    logic        hold_taken;
    int          hold_left;

    terminal_line_editor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .ev      (ev_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("terminal_line_editor_test: FAIL");
        $finish;
    end

    function automatic void due_event(input ev_kind_t kind, input logic [7:0] ch,
                                      input logic last);
        line_event_t e;
        e.kind = kind;
        e.ch   = ch;
        e.len  = 7'(line_len);
        e.cur  = 7'(cur_pos);
        e.last = last;
        line_events_due.push_back(e);
    endfunction

    // Apply one received byte to the shadow line and queue its events.
    function automatic void edit_line(input logic [7:0] b);
        ev_kind_t   kind;
        logic [7:0] echo_ch;
        logic [7:0] ch;
        int         n;
        int         i;
        kind    = EV_IGNORED;
        echo_ch = 8'h00;
        case (esc_state)
            ESC_SEEN:
            begin
                if (b == CH_LBRACKET)
                begin
                    esc_state = ESC_BRACKET;
                    kind      = EV_PENDING;
                end
                else
                    esc_state = ESC_IDLE;
            end
            ESC_BRACKET:
            begin
                esc_state = ESC_IDLE;
                if (b == CH_UPPER_A)
                    kind = EV_UP;
                else if (b == CH_UPPER_B)
                    kind = EV_DOWN;
                else if (b == CH_UPPER_C)
                begin
                    if (cur_pos < line_len)
                    begin
                        cur_pos++;
                        kind = EV_RIGHT;
                    end
                end
                else if (b == CH_UPPER_D)
                begin
                    if (cur_pos > 0)
                    begin
                        cur_pos--;
                        kind = EV_LEFT;
                    end
                end
            end
            default:
            begin
                esc_state = ESC_IDLE;
                if (b == CH_ESC)
                begin
                    esc_state = ESC_SEEN;
                    kind      = EV_PENDING;
                end
                else if (b == CH_CR || b == CH_LF || b == CH_NUL)
                begin
                    n        = line_len;
                    line_len = 0;
                    cur_pos  = 0;
                    if (n == 0)
                        due_event(EV_EMPTY, 8'h00, 1'b1);
                    for (i = 0; i < n; i++)
                    begin
                        ch = line_mem[i];
                        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
                            ch = ch + (CH_LOWER_A - CH_UPPER_A);
                        due_event(EV_LINECHAR, ch, i == n - 1);
                    end
                    return;
                end
                else if (b == del_code)
                begin
                    if (line_len > 0 && cur_pos > 0)
                    begin
                        kind = (cur_pos == line_len) ? EV_ERASE : EV_REDRAW;
                        line_len--;
                        cur_pos--;
                        for (i = cur_pos; i < line_len; i++)
                            line_mem[i] = line_mem[i + 1];
                    end
                end
                else if (line_len < TLE_LINE_MAX)
                begin
                    if (cur_pos == line_len)
                    begin
                        kind    = EV_ECHO;
                        echo_ch = b;
                    end
                    else
                    begin
                        kind = EV_REDRAW;
                        for (i = line_len; i > cur_pos; i--)
                            line_mem[i] = line_mem[i - 1];
                    end
                    line_mem[cur_pos] = b;
                    line_len++;
                    cur_pos++;
                end
            end
        endcase
        due_event(kind, echo_ch, 1'b1);
    endfunction

    // Mostly well-formed typing: text, deletes, arrow sequences and enters,
    // with broken escapes and raw bytes mixed in.
    task automatic queue_keystrokes(input int count);
        int         pushed;
        int         pick;
        int         j;
        logic [7:0] burst [$];
        pushed = 0;
        while (pushed < count)
        begin
            burst.delete();
            pick = $urandom_range(99);
            if (pick < 38)
            begin
                if ($urandom_range(3) == 0)
                    burst.push_back(8'($urandom_range(255)));
                else
                    burst.push_back(8'($urandom_range(8'h7E, 8'h20)));
            end
            else if (pick < 50)
                burst.push_back(del_code);
            else if (pick < 68)
            begin
                burst.push_back(CH_ESC);
                burst.push_back(CH_LBRACKET);
                burst.push_back(CH_UPPER_A + 8'($urandom_range(3)));
            end
            else if (pick < 73)
            begin
                burst.push_back(CH_ESC);
                burst.push_back(CH_LBRACKET);
                burst.push_back(8'($urandom_range(255)));
            end
            else if (pick < 78)
            begin
                burst.push_back(CH_ESC);
                burst.push_back(8'($urandom_range(255)));
            end
            else if (pick < 87)
            begin
                case ($urandom_range(2))
                    0:       burst.push_back(CH_CR);
                    1:       burst.push_back(CH_LF);
                    default: burst.push_back(CH_NUL);
                endcase
            end
            else if (pick < 98)
                burst.push_back(8'($urandom_range(255)));
            else
            begin
                // long run of text, often up to a full line
                repeat ($urandom_range(70, 40))
                    burst.push_back(8'($urandom_range(8'h7E, 8'h20)));
            end
            for (j = 0; j < burst.size(); j++)
                rx_pending.push_back(burst[j]);
            pushed += burst.size();
        end
    endtask

    task automatic wait_line_idle();
        while (rx_pending.size() != 0 || rx_ch.valid || line_events_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the delete code, then read it back
    task automatic set_delete_code(input logic [7:0] code);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DELETE_CODE_ADDR;
        pwdata  <= {24'h0, code};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        del_code = code;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== code)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("delete_code readback: expected %h, got %h", code, prdata[7:0]);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // rx driver
    always @(negedge clk)
    begin
        if (!rst_n)
            rx_ch.valid <= 1'b0;
        else if (!rx_ch.valid || rx_taken)
        begin
            if (rx_pending.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                rx_ch.rx_byte <= rx_pending.pop_front();
                rx_ch.valid   <= 1'b1;
            end
            else
                rx_ch.valid <= 1'b0;
        end
    end

    // ev ready, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (!rst_n)
            ev_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            ev_ch.ready <= 1'b0;
        end
        else
            ev_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: predict on rx items, check on ev items
    always @(posedge clk)
    begin : monitor
        line_event_t want;
        rx_taken <= rx_ch.valid && rx_ch.ready;
        if (rst_n && rx_ch.valid && rx_ch.ready)
            edit_line(rx_ch.rx_byte);
        if (rst_n && ev_ch.valid && ev_ch.ready)
        begin
            if (line_events_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d byte %h len %0d cur %0d last %b",
                             ev_ch.event_kind, ev_ch.out_byte, ev_ch.line_length,
                             ev_ch.cursor_pos, ev_ch.last);
            end
            else
            begin
                want = line_events_due.pop_front();
                if (ev_ch.event_kind !== want.kind || ev_ch.out_byte !== want.ch ||
                    ev_ch.line_length !== want.len || ev_ch.cursor_pos !== want.cur ||
                    ev_ch.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("event mismatch: expected kind %0d byte %h len %0d cur %0d last %b, ",
                               want.kind, want.ch, want.len, want.cur, want.last);
                        $display("got kind %0d byte %h len %0d cur %0d last %b",
                                 ev_ch.event_kind, ev_ch.out_byte, ev_ch.line_length,
                                 ev_ch.cursor_pos, ev_ch.last);
                    end
                end
            end
        end
    end

    initial
    begin
        int k;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        ev_ch.ready   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = 32'h0;
        rx_taken      = 1'b0;
        no_idle       = 1'b0;
        hold_go       = 1'b0;
        hold_taken    = 1'b0;
        hold_left     = 0;
        mismatches    = 0;
        line_len      = 0;
        cur_pos       = 0;
        esc_state     = ESC_IDLE;
        del_code      = DELETE_CODE_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pass with the reset delete code
        rx_pending = '{CH_NUL, CH_UPPER_A, CH_UPPER_Z, 8'h40, 8'hFF,
                       CH_ESC, CH_LBRACKET, CH_UPPER_D, 8'h71, DELETE_CODE_RESET,
                       CH_ESC, CH_LBRACKET, CH_UPPER_C,
                       CH_ESC, CH_LBRACKET, CH_UPPER_C, DELETE_CODE_RESET,
                       CH_ESC, 8'h78, CH_ESC, CH_LBRACKET, CH_UPPER_A,
                       CH_ESC, CH_LBRACKET, CH_UPPER_B, CH_LF,
                       CH_ESC, CH_LBRACKET, CH_UPPER_D, DELETE_CODE_RESET, CH_CR};
        wait_line_idle();

        // full line: overflow, edits at capacity, then a 64-char enter
        set_delete_code(8'hFF);
        for (k = 0; k < TLE_LINE_MAX + 2; k++)
            rx_pending.push_back(8'($urandom_range(8'h7E, 8'h20)));
        rx_pending.push_back(CH_ESC);
        rx_pending.push_back(CH_LBRACKET);
        rx_pending.push_back(CH_UPPER_D);
        rx_pending.push_back(8'h6B);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'h6B);
        rx_pending.push_back(8'h6B);
        rx_pending.push_back(CH_CR);
        queue_keystrokes(80);
        wait_line_idle();

        // delete code shadowed by enter, then by escape
        set_delete_code(8'h00);
        queue_keystrokes(60);
        wait_line_idle();
        set_delete_code(CH_ESC);
        queue_keystrokes(50);
        wait_line_idle();

        // backspace, with the event side held off so the input backs up
        set_delete_code(8'h08);
        hold_go = 1'b1;
        queue_keystrokes(120);
        wait_line_idle();

        // printable delete code
        set_delete_code(8'h78);
        queue_keystrokes(70);
        wait_line_idle();

        // back to the reset code, no idling, with a drain in the middle
        set_delete_code(DELETE_CODE_RESET);
        no_idle = 1'b1;
        queue_keystrokes(50);
        wait_line_idle();
        queue_keystrokes(50);
        wait_line_idle();
        no_idle = 1'b0;

        repeat (20) @(posedge clk);
        if (mismatches == 0 && line_events_due.size() == 0)
            $display("terminal_line_editor_test: PASS");
        else
            $display("terminal_line_editor_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
